@@ rtl/trapezoidal_svf_lowpass_defines.svh @@
// Assertion macros shared by the checker of the low-pass state variable filter.
// Needs a clk and an active-low rst_n in the scope where a macro is used.
`ifndef TRAPEZOIDAL_SVF_LOWPASS_DEFINES_SVH
`define TRAPEZOIDAL_SVF_LOWPASS_DEFINES_SVH

// The consequent must hold in the cycle in which the antecedent ends.
`define TSVF_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent ends.
`define TSVF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/tsvf_pkg.sv @@
// Types and constants shared by the low-pass state variable filter modules.
// Has no dependencies.
package tsvf_pkg;

    localparam int GAIN_W  = 24;
    localparam int DAMP_W  = 18;
    localparam int COEF_W  = 25;
    localparam int PADDR_W = 3;

    typedef logic [COEF_W-1:0] coef_t;

    localparam coef_t COEF_UNITY = 25'h1000000;
    localparam logic [DAMP_W-1:0] DAMPING_RESET = 18'd131072;

    typedef struct packed {
        coef_t coef_one;
        coef_t coef_two;
        coef_t coef_three;
    } coef_set_t;

    typedef enum logic [0:0] {
        REG_CUTOFF_GAIN = 1'b0,
        REG_DAMPING     = 1'b1
    } reg_index_t;

    typedef enum logic [2:0] {
        DERIV_IDLE,
        DERIV_DEN,
        DERIV_DIV,
        DERIV_TWO,
        DERIV_THREE
    } deriv_state_t;

endpackage

@@ rtl/tsvf_coef.sv @@
// Coefficient unit: derives the three filter coefficients from gain and damping.
// Uses a bit-serial divider; depends on tsvf_pkg.
module tsvf_coef (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [tsvf_pkg::GAIN_W-1:0] gain,
    input  logic [tsvf_pkg::DAMP_W-1:0] damping,
    output tsvf_pkg::coef_set_t         coefs,
    output logic                        busy
);

    localparam logic [48:0] DEN_BIAS = 49'd1 << 32;
    localparam logic [48:0] REM_BIAS = 49'd1 << 31;
    localparam logic [48:0] RND_HALF = 49'd1 << 15;

    tsvf_pkg::deriv_state_t state_reg, state_next;
    tsvf_pkg::coef_set_t    coef_reg, coef_next;
    logic [48:0]            den_reg, den_next;
    logic [48:0]            rem_reg, rem_next;
    logic [24:0]            numlo_reg, numlo_next;
    logic [24:0]            quot_reg, quot_next;
    logic [4:0]             cnt_reg, cnt_next;

    logic [24:0] gk_sum;
    logic [48:0] den_calc;
    logic [49:0] trial;
    logic [49:0] diff;
    logic        ge;
    logic [24:0] quot_shift;
    logic [24:0] scale_coef;
    logic [48:0] scale_prod;

    function automatic tsvf_pkg::coef_t clamp_unity(input logic [32:0] v);
        if (v > {8'b0, tsvf_pkg::COEF_UNITY})
            return tsvf_pkg::COEF_UNITY;
        else
            return v[24:0];
    endfunction

    assign gk_sum     = {1'b0, gain} + {7'b0, damping};
    assign den_calc   = ({25'b0, gain} * {24'b0, gk_sum}) + DEN_BIAS;
    assign trial      = {rem_reg, numlo_reg[24]};
    assign diff       = trial - {1'b0, den_reg};
    assign ge         = (trial >= {1'b0, den_reg});
    assign quot_shift = {quot_reg[23:0], ge};
    assign scale_coef = (state_reg == tsvf_pkg::DERIV_TWO) ? coef_reg.coef_one
                                                            : coef_reg.coef_two;
    assign scale_prod = ({25'b0, gain} * {24'b0, scale_coef}) + RND_HALF;

    always_comb
    begin
        state_next = state_reg;
        coef_next  = coef_reg;
        den_next   = den_reg;
        rem_next   = rem_reg;
        numlo_next = numlo_reg;
        quot_next  = quot_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            tsvf_pkg::DERIV_IDLE:
            begin
                if (start)
                    state_next = tsvf_pkg::DERIV_DEN;
            end
            tsvf_pkg::DERIV_DEN:
            begin
                // The dividend is 2^56 plus half the divisor; its top bits seed
                // the remainder and its low 25 bits are shifted in one a cycle.
                den_next   = den_calc;
                rem_next   = REM_BIAS + {26'b0, den_calc[48:26]};
                numlo_next = den_calc[25:1];
                quot_next  = '0;
                cnt_next   = 5'd24;
                state_next = tsvf_pkg::DERIV_DIV;
            end
            tsvf_pkg::DERIV_DIV:
            begin
                rem_next   = ge ? diff[48:0] : trial[48:0];
                numlo_next = {numlo_reg[23:0], 1'b0};
                quot_next  = quot_shift;
                cnt_next   = cnt_reg - 5'd1;
                if (cnt_reg == 5'd0)
                begin
                    coef_next.coef_one = clamp_unity({8'b0, quot_shift});
                    state_next         = tsvf_pkg::DERIV_TWO;
                end
            end
            tsvf_pkg::DERIV_TWO:
            begin
                coef_next.coef_two = clamp_unity(scale_prod[48:16]);
                state_next         = tsvf_pkg::DERIV_THREE;
            end
            tsvf_pkg::DERIV_THREE:
            begin
                coef_next.coef_three = clamp_unity(scale_prod[48:16]);
                state_next           = tsvf_pkg::DERIV_IDLE;
            end
            default:
            begin
                state_next = tsvf_pkg::DERIV_IDLE;
            end
        endcase
        // A register write part-way through a derivation starts it again
        // from the new register values.
        if (start)
            state_next = tsvf_pkg::DERIV_DEN;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg           <= tsvf_pkg::DERIV_IDLE;
            coef_reg.coef_one   <= tsvf_pkg::COEF_UNITY;
            coef_reg.coef_two   <= '0;
            coef_reg.coef_three <= '0;
        end
        else
        begin
            state_reg <= state_next;
            coef_reg  <= coef_next;
        end
    end

    always_ff @(posedge clk)
    begin
        den_reg   <= den_next;
        rem_reg   <= rem_next;
        numlo_reg <= numlo_next;
        quot_reg  <= quot_next;
        cnt_reg   <= cnt_next;
    end

    assign coefs = coef_reg;
    assign busy  = (state_reg != tsvf_pkg::DERIV_IDLE);

endmodule

@@ rtl/tsvf_core.sv @@
// Sample datapath: input register, integrator update and the result register.
// Depends on tsvf_pkg for the coefficient bundle.
module tsvf_core #(
    parameter int SAMPLE_BITS = 24
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          hold,
    input  tsvf_pkg::coef_set_t           coefs,
    input  logic                          sample_valid,
    output logic                          sample_stall,
    input  logic signed [SAMPLE_BITS-1:0] sample_in,
    output logic                          lowpass_valid,
    input  logic                          lowpass_stall,
    output logic signed [SAMPLE_BITS-1:0] lowpass_out
);

    localparam int YW = (SAMPLE_BITS >= 24) ? SAMPLE_BITS + 8 : SAMPLE_BITS + 9;

    logic signed [23:0] x_aligned;
    logic signed [23:0] x_reg, x_next;
    logic               x_valid_reg, x_valid_next;
    logic signed [31:0] ic1_reg, ic1_next, ic2_reg, ic2_next;
    logic               out_valid_reg, out_valid_next;
    logic [SAMPLE_BITS-1:0] out_reg, out_next;
    logic               accept, advance;

    logic signed [32:0] v3;
    logic signed [58:0] p_a, p_b, p_c, p_d;
    logic signed [59:0] s1, s2;
    logic signed [35:0] q1, q2;
    logic signed [36:0] v2_wide;
    logic signed [31:0] v1, v2;
    logic signed [33:0] ic1_wide, ic2_wide;
    logic signed [YW-1:0] y_wide;
    logic [YW-SAMPLE_BITS:0] top_bits;
    logic               y_ovf;

    function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
        if (v > 40'sd2147483647)
            return 32'sh7FFFFFFF;
        else if (v < -40'sd2147483648)
            return 32'sh80000000;
        else
            return v[31:0];
    endfunction

    generate
        if (SAMPLE_BITS < 24)
        begin : g_in_narrow
            assign x_aligned = {sample_in, {(24 - SAMPLE_BITS){1'b0}}};
        end
        else if (SAMPLE_BITS == 24)
        begin : g_in_equal
            assign x_aligned = sample_in;
        end
        else
        begin : g_in_wide
            assign x_aligned = sample_in[SAMPLE_BITS-1 -: 24];
        end
    endgenerate

    assign v3  = {{9{x_reg[23]}}, x_reg} - {ic2_reg[31], ic2_reg};
    assign p_a = $signed({1'b0, coefs.coef_one}) * ic1_reg;
    assign p_b = $signed({1'b0, coefs.coef_two}) * v3;
    assign p_c = $signed({1'b0, coefs.coef_two}) * ic1_reg;
    assign p_d = $signed({1'b0, coefs.coef_three}) * v3;
    assign s1  = {p_a[58], p_a} + {p_b[58], p_b} + 60'sd8388608;
    assign s2  = {p_c[58], p_c} + {p_d[58], p_d} + 60'sd8388608;
    assign q1  = s1[59:24];
    assign q2  = s2[59:24];

    assign v1       = sat32({{4{q1[35]}}, q1});
    assign v2_wide  = {{5{ic2_reg[31]}}, ic2_reg} + {q2[35], q2};
    assign v2       = sat32({{3{v2_wide[36]}}, v2_wide});
    assign ic1_wide = {v1[31], v1, 1'b0} - {{2{ic1_reg[31]}}, ic1_reg};
    assign ic2_wide = {v2[31], v2, 1'b0} - {{2{ic2_reg[31]}}, ic2_reg};

    generate
        if (SAMPLE_BITS > 24)
        begin : g_out_wide
            assign y_wide = {v2, {(SAMPLE_BITS - 24){1'b0}}};
        end
        else if (SAMPLE_BITS == 24)
        begin : g_out_equal
            assign y_wide = v2;
        end
        else
        begin : g_out_narrow
            localparam int SHR = 24 - SAMPLE_BITS;
            localparam logic signed [32:0] HALF = 33'sd1 <<< (SHR - 1);
            logic signed [32:0] rounded;
            assign rounded = {v2[31], v2} + HALF;
            assign y_wide  = rounded[32:SHR];
        end
    endgenerate

    assign top_bits = y_wide[YW-1:SAMPLE_BITS-1];
    assign y_ovf    = !((&top_bits) || !(|top_bits));

    assign advance      = x_valid_reg && (!out_valid_reg || !lowpass_stall);
    assign sample_stall = hold || (x_valid_reg && !advance);
    assign accept       = sample_valid && !sample_stall;

    always_comb
    begin
        x_next         = accept ? x_aligned : x_reg;
        x_valid_next   = accept ? 1'b1 : (advance ? 1'b0 : x_valid_reg);
        ic1_next       = ic1_reg;
        ic2_next       = ic2_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && lowpass_stall;
        if (advance)
        begin
            ic1_next       = sat32({{6{ic1_wide[33]}}, ic1_wide});
            ic2_next       = sat32({{6{ic2_wide[33]}}, ic2_wide});
            out_valid_next = 1'b1;
            if (y_ovf)
                out_next = {y_wide[YW-1], {(SAMPLE_BITS - 1){~y_wide[YW-1]}}};
            else
                out_next = y_wide[SAMPLE_BITS-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            ic1_reg       <= '0;
            ic2_reg       <= '0;
        end
        else
        begin
            x_valid_reg   <= x_valid_next;
            out_valid_reg <= out_valid_next;
            ic1_reg       <= ic1_next;
            ic2_reg       <= ic2_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg   <= x_next;
        out_reg <= out_next;
    end

    assign lowpass_valid = out_valid_reg;
    assign lowpass_out   = out_reg;

endmodule

@@ rtl/trapezoidal_svf_lowpass.sv @@
// Top level of the trapezoidal state variable low-pass filter with its register port.
// Instantiates tsvf_coef and tsvf_core; depends on tsvf_pkg.
//
// The filter takes one sample word per clock while sample_stall is low and registers each
// accepted word, then forms the low-pass word in the result register, both integrators being
// updated in the same cycle as the output is formed. Writing cutoff_gain (byte address 0)
// or damping (byte address 4) starts a coefficient derivation that holds sample_stall high
// from the access cycle until it completes; the bit-serial divider forms the first
// coefficient one quotient bit a cycle. A write during a derivation starts it again.
module trapezoidal_svf_lowpass #(
    parameter int SAMPLE_BITS = 24
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [tsvf_pkg::PADDR_W-1:0]   paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready,
    input  logic                           sample_valid,
    output logic                           sample_stall,
    input  logic signed [SAMPLE_BITS-1:0]  sample_in,
    output logic                           lowpass_valid,
    input  logic                           lowpass_stall,
    output logic signed [SAMPLE_BITS-1:0]  lowpass_out
);

    logic [tsvf_pkg::GAIN_W-1:0] gain_reg, gain_next;
    logic [tsvf_pkg::DAMP_W-1:0] damping_reg, damping_next;
    tsvf_pkg::reg_index_t        reg_index;
    tsvf_pkg::coef_set_t         coefs;
    logic                        wr_en;
    logic                        deriv_busy;

    assign pready    = 1'b1;
    assign wr_en     = psel && penable && pwrite && pready;
    assign reg_index = tsvf_pkg::reg_index_t'(paddr[2]);

    always_comb
    begin
        gain_next    = gain_reg;
        damping_next = damping_reg;
        prdata       = '0;
        case (reg_index)
            tsvf_pkg::REG_CUTOFF_GAIN:
            begin
                prdata = {8'b0, gain_reg};
                if (wr_en)
                    gain_next = pwdata[tsvf_pkg::GAIN_W-1:0];
            end
            tsvf_pkg::REG_DAMPING:
            begin
                prdata = {14'b0, damping_reg};
                if (wr_en)
                    damping_next = pwdata[tsvf_pkg::DAMP_W-1:0];
            end
            default:
            begin
                prdata = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg    <= '0;
            damping_reg <= tsvf_pkg::DAMPING_RESET;
        end
        else
        begin
            gain_reg    <= gain_next;
            damping_reg <= damping_next;
        end
    end

    tsvf_coef u_coef (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (wr_en),
        .gain    (gain_reg),
        .damping (damping_reg),
        .coefs   (coefs),
        .busy    (deriv_busy)
    );

    tsvf_core #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_core (
        .clk           (clk),
        .rst_n         (rst_n),
        .hold          (deriv_busy || wr_en),
        .coefs         (coefs),
        .sample_valid  (sample_valid),
        .sample_stall  (sample_stall),
        .sample_in     (sample_in),
        .lowpass_valid (lowpass_valid),
        .lowpass_stall (lowpass_stall),
        .lowpass_out   (lowpass_out)
    );

endmodule

@@ rtl/tsvf_checker.sv @@
// Port-level checker for the low-pass state variable filter, bound to its top level.
// Depends on the assertion macros header and tsvf_pkg.
`include "trapezoidal_svf_lowpass_defines.svh"

module tsvf_checker #(
    parameter int SAMPLE_BITS = 24
) (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          psel,
    input logic                          penable,
    input logic                          pwrite,
    input logic                          pready,
    input logic [tsvf_pkg::PADDR_W-1:0]  paddr,
    input logic [31:0]                   pwdata,
    input logic [31:0]                   prdata,
    input logic                          sample_stall,
    input logic                          lowpass_valid,
    input logic                          lowpass_stall,
    input logic [SAMPLE_BITS-1:0]        lowpass_out
);

    `TSVF_ASSERT_NEXT(a_cfg_write_stalls, psel && penable && pwrite && pready, sample_stall, "Input taken during coefficient derivation")
    `TSVF_ASSERT_SAME(a_gain_readback, psel && penable && pwrite && pready && !paddr[2] ##1 !paddr[2], prdata[23:0] == $past(pwdata[23:0]), "Cutoff gain reads back wrong")
    `TSVF_ASSERT_NEXT(a_out_valid_held, lowpass_valid && lowpass_stall, lowpass_valid, "Result word dropped while stalled")
    `TSVF_ASSERT_NEXT(a_out_word_held, lowpass_valid && lowpass_stall, $stable(lowpass_out), "Result word changed while stalled")

endmodule

bind trapezoidal_svf_lowpass tsvf_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_tsvf_checker (.*);

@@ tb/trapezoidal_svf_lowpass_tb.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for the trapezoidal state variable low-pass filter: a directed
// table, then randomised phases with register writes, idle gaps and output back-pressure.
// Depends on tsvf_pkg and the trapezoidal_svf_lowpass RTL; needs no other file.
module trapezoidal_svf_lowpass_tb;
    import tsvf_pkg::*;

    localparam int SAMPLE_W = 24;
    localparam int PHASES = 8;
    localparam int PHASE_ITEMS = 50;
    localparam int LONG_HOLD = 80;
    localparam int TAIL_CYCLES = 12;
    localparam int DIRECTED_ROWS = 30;
    localparam longint Q23_HALF = 64'sd1 << 23;
    localparam longint SAT32_HI = 64'sd2147483647;
    localparam longint SAT32_LO = -64'sd2147483648;
    localparam longint OUT_HI = (64'sd1 << (SAMPLE_W - 1)) - 1;
    localparam longint OUT_LO = -(64'sd1 << (SAMPLE_W - 1));
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 24'sh7FFFFF;
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 24'sh800000;

    typedef struct {
        bit                         is_write;
        reg_index_t                 reg_sel;
        logic [31:0]                wdata;
        logic signed [SAMPLE_W-1:0] sample;
        bit                         known;
        logic signed [SAMPLE_W-1:0] known_out;
    } dir_row_t;

    logic                        clk;
    logic                        rst_n;
    logic                        psel;
    logic                        penable;
    logic                        pwrite;
    logic [PADDR_W-1:0]          paddr;
    logic [31:0]                 pwdata;
    logic [31:0]                 prdata;
    logic                        pready;
    logic                        sample_valid;
    logic                        sample_stall;
    logic signed [SAMPLE_W-1:0]  sample_in;
    logic                        lowpass_valid;
    logic                        lowpass_stall;
    logic signed [SAMPLE_W-1:0]  lowpass_out;

    logic [GAIN_W-1:0]           gain_reg;
    logic [DAMP_W-1:0]           damp_reg;
    coef_set_t                   coefs;
    logic signed [31:0]          integ_one;
    logic signed [31:0]          integ_two;

    logic signed [SAMPLE_W-1:0]  pending_lowpass[$];
    logic signed [SAMPLE_W-1:0]  want_word;
    logic signed [SAMPLE_W-1:0]  predicted_word;
    bit                          row_known;
    logic signed [SAMPLE_W-1:0]  row_known_val;
    bit                          quiet;
    bit                          hold_off_req;
    int                          mismatches;
    int                          samples_accepted;
    int                          results_checked;
    int                          writes_done;
    int                          holds_done;

    dir_row_t directed_rows [DIRECTED_ROWS] = '{
        '{1'b0, REG_CUTOFF_GAIN, 32'h0, SAMPLE_MAX, 1'b1, 24'sh000000},
        '{1'b0, REG_CUTOFF_GAIN, 32'h0, SAMPLE_MIN, 1'b1, 24'sh000000},
        '{1'b0, REG_CUTOFF_GAIN, 32'h0, 24'sh000000, 1'b1, 24'sh000000},
        '{1'b0, REG_CUTOFF_GAIN, 32'h0, 24'sh000001, 1'b1, 24'sh000000},
        '{1'b0, REG_CUTOFF_GAIN, 32'h0, 24'shFFFFFF, 1'b1, 24'sh000000},
        '{1'b1, REG_CUTOFF_GAIN, 32'h00004000, 24'sh0, 1'b0, 24'sh0},
        '{1'b1, REG_DAMPING, 32'h00008000, 24'sh0, 1'b0, 24'sh0},
        '{1'b0, REG_CUTOFF_GAIN, 32'h0, SAMPLE_MAX, 1'b0, 24'sh0},
        '{1'b0, REG_CUTOFF_GAIN, 32'h0, SAMPLE_MAX, 1'b0, 24'sh0},
        '{1'b0, REG_CUTOFF_GAIN, 32'h0, SAMPLE_MAX, 1'b0, 24'sh0},
        '{1'b0, REG_CUTOFF_GAIN, 32'h0, SAMPLE_MIN, 1'b0, 24'sh0},
        '{1'b0, REG_CUTOFF_GAIN, 32'h0, SAMPLE_MIN, 1'b0, 24'sh0},
        '{1'b0, REG_CUTOFF_GAIN, 32'h0, SAMPLE_MIN, 1'b0, 24'sh0},
        '{1'b0, REG_CUTOFF_GAIN, 32'h0, 24'sh000000, 1'b0, 24'sh0},
        '{1'b1, REG_CUTOFF_GAIN, 32'hFFFFFFFF, 24'sh0, 1'b0, 24'sh0},
        '{1'b1, REG_DAMPING, 32'hFFFFFFFF, 24'sh0, 1'b0, 24'sh0},
        '{1'b0, REG_CUTOFF_GAIN, 32'h0, SAMPLE_MAX, 1'b0, 24'sh0},
        '{1'b0, REG_CUTOFF_GAIN, 32'h0, SAMPLE_MIN, 1'b0, 24'sh0},
        '{1'b0, REG_CUTOFF_GAIN, 32'h0, 24'sh000000, 1'b0, 24'sh0},
        '{1'b1, REG_DAMPING, 32'h00000000, 24'sh0, 1'b0, 24'sh0},
        '{1'b1, REG_CUTOFF_GAIN, 32'h00010000, 24'sh0, 1'b0, 24'sh0},
        '{1'b0, REG_CUTOFF_GAIN, 32'h0, SAMPLE_MAX, 1'b0, 24'sh0},
        '{1'b0, REG_CUTOFF_GAIN, 32'h0, SAMPLE_MIN, 1'b0, 24'sh0},
        '{1'b0, REG_CUTOFF_GAIN, 32'h0, SAMPLE_MAX, 1'b0, 24'sh0},
        '{1'b0, REG_CUTOFF_GAIN, 32'h0, SAMPLE_MIN, 1'b0, 24'sh0},
        '{1'b1, REG_CUTOFF_GAIN, 32'hAB000000, 24'sh0, 1'b0, 24'sh0},
        '{1'b0, REG_CUTOFF_GAIN, 32'h0, SAMPLE_MAX, 1'b0, 24'sh0},
        '{1'b0, REG_CUTOFF_GAIN, 32'h0, 24'shFFFFFF, 1'b0, 24'sh0},
        '{1'b1, REG_DAMPING, 32'h00020000, 24'sh0, 1'b0, 24'sh0},
        '{1'b0, REG_CUTOFF_GAIN, 32'h0, 24'sh000001, 1'b0, 24'sh0}
    };

    trapezoidal_svf_lowpass #(
        .SAMPLE_BITS(SAMPLE_W)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready),
        .sample_valid(sample_valid),
        .sample_stall(sample_stall),
        .sample_in(sample_in),
        .lowpass_valid(lowpass_valid),
        .lowpass_stall(lowpass_stall),
        .lowpass_out(lowpass_out)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("FAIL");
        $finish;
    end

    task automatic note_mismatch(string what, longint got, longint want);
        if (mismatches < 100)
            $display("mismatch: %s, got %0d, wanted %0d, at %0t", what, got, want, $realtime);
        mismatches++;
    endtask

    function automatic longint clamp_to(longint v, longint lo, longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function automatic longint round_q47(longint v);
        return (v + Q23_HALF) >>> 24;
    endfunction

    function automatic coef_t limit_unity(longint unsigned c);
        return (c > COEF_UNITY) ? COEF_UNITY : coef_t'(c);
    endfunction

    function void derive_coefficients();
        longint unsigned g;
        longint unsigned den;
        longint unsigned c;
        g = gain_reg;
        den = (64'd1 << 32) + g * (g + damp_reg);
        c = ((64'd1 << 56) + den / 2) / den;
        coefs.coef_one = limit_unity(c);
        c = (g * coefs.coef_one + (64'd1 << 15)) >> 16;
        coefs.coef_two = limit_unity(c);
        c = (g * coefs.coef_two + (64'd1 << 15)) >> 16;
        coefs.coef_three = limit_unity(c);
    endfunction

    function logic signed [SAMPLE_W-1:0] predict_lowpass(logic signed [SAMPLE_W-1:0] x);
        longint c1;
        longint c2;
        longint c3;
        longint i1;
        longint i2;
        longint v1;
        longint v2;
        longint v3;
        c1 = {39'd0, coefs.coef_one};
        c2 = {39'd0, coefs.coef_two};
        c3 = {39'd0, coefs.coef_three};
        i1 = integ_one;
        i2 = integ_two;
        v3 = longint'(x) - i2;
        v1 = clamp_to(round_q47(c1 * i1 + c2 * v3), SAT32_LO, SAT32_HI);
        v2 = clamp_to(i2 + round_q47(c2 * i1 + c3 * v3), SAT32_LO, SAT32_HI);
        integ_one = 32'(clamp_to(2 * v1 - i1, SAT32_LO, SAT32_HI));
        integ_two = 32'(clamp_to(2 * v2 - i2, SAT32_LO, SAT32_HI));
        return SAMPLE_W'(clamp_to(v2, OUT_LO, OUT_HI));
    endfunction

    function automatic int next_gap();
        int r;
        if (quiet)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 70)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] random_sample(int idx);
        int r;
        int v;
        r = $urandom_range(0, 99);
        if (r < 40)
            return SAMPLE_W'($urandom);
        if (r < 65)
        begin
            v = $urandom_range(0, 4095) - 2048;
            return SAMPLE_W'(v);
        end
        if (r < 85)
            return ((idx / 8) % 2 == 1) ? SAMPLE_MAX : SAMPLE_MIN;
        case ($urandom_range(0, 5))
            0: return SAMPLE_MAX;
            1: return SAMPLE_MIN;
            2: return SAMPLE_W'(SAMPLE_MAX - 1);
            3: return SAMPLE_W'(SAMPLE_MIN + 1);
            4: return 24'sh000000;
            default: return 24'shFFFFFF;
        endcase
    endfunction

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (lowpass_valid && !lowpass_stall)
            begin
                if (pending_lowpass.size() == 0)
                    note_mismatch("low-pass word with none outstanding", lowpass_out, 0);
                else
                begin
                    want_word = pending_lowpass.pop_front();
                    if (lowpass_out !== want_word)
                        note_mismatch("lowpass_out", lowpass_out, want_word);
                    results_checked++;
                end
            end
            if (sample_valid && !sample_stall)
            begin
                predicted_word = predict_lowpass(sample_in);
                pending_lowpass.push_back(row_known ? row_known_val : predicted_word);
                samples_accepted++;
            end
        end
    end

    initial
    begin : receiver
        int r;
        lowpass_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_off_req)
            begin
                lowpass_stall <= 1'b1;
                repeat (LONG_HOLD - 1) @(negedge clk);
                hold_off_req = 1'b0;
                holds_done++;
            end
            else if (quiet)
                lowpass_stall <= 1'b0;
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 70)
                    lowpass_stall <= 1'b0;
                else
                begin
                    lowpass_stall <= 1'b1;
                    repeat ((r < 97) ? $urandom_range(0, 2) : $urandom_range(8, 40))
                        @(negedge clk);
                end
            end
        end
    end

    task automatic send_sample(logic signed [SAMPLE_W-1:0] x, bit known,
                               logic signed [SAMPLE_W-1:0] known_val);
        int gap;
        @(negedge clk);
        row_known = known;
        row_known_val = known_val;
        sample_valid <= 1'b1;
        sample_in <= x;
        do @(posedge clk); while (!(sample_valid && !sample_stall));
        gap = next_gap();
        if (gap > 0)
        begin
            @(negedge clk);
            sample_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    task automatic settle_block();
        @(negedge clk);
        sample_valid <= 1'b0;
        while (pending_lowpass.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_register(reg_index_t sel, logic [31:0] data);
        logic [31:0] got;
        logic [31:0] held;
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {sel, 2'b00};
        pwdata <= data;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (sel == REG_CUTOFF_GAIN)
            gain_reg = data[GAIN_W-1:0];
        else
            damp_reg = data[DAMP_W-1:0];
        derive_coefficients();
        held = (sel == REG_CUTOFF_GAIN) ? 32'(gain_reg) : 32'(damp_reg);
        @(negedge clk);
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        got = prdata;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        if (got !== held)
            note_mismatch("register read-back", got, held);
        writes_done++;
    endtask

    initial
    begin : stimulus
        int r;
        logic [31:0] value;
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        sample_valid = 1'b0;
        sample_in = '0;
        row_known = 1'b0;
        row_known_val = '0;
        quiet = 1'b0;
        hold_off_req = 1'b0;
        gain_reg = '0;
        damp_reg = DAMPING_RESET;
        coefs = '{coef_one: COEF_UNITY, coef_two: '0, coef_three: '0};
        integ_one = '0;
        integ_two = '0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].is_write)
            begin
                settle_block();
                write_register(directed_rows[i].reg_sel, directed_rows[i].wdata);
            end
            else
                send_sample(directed_rows[i].sample, directed_rows[i].known,
                            directed_rows[i].known_out);
        end

        for (int phase = 0; phase < PHASES; phase++)
        begin
            settle_block();
            r = $urandom_range(0, 9);
            if (r < 7)
                value = $urandom_range(0, 32'h8000);
            else if (r < 9)
                value = $urandom_range(0, 32'h40000);
            else
                value = $urandom & 32'hFFFFFF;
            write_register(REG_CUTOFF_GAIN, ($urandom & 32'hFF000000) | value);
            if (phase < 2 || $urandom_range(0, 1) == 1)
            begin
                value = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 131072)
                                                   : $urandom_range(0, 262143);
                write_register(REG_DAMPING, ($urandom & 32'hFFFC0000) | value);
            end
            quiet = (phase == 2);
            if (phase == 4)
                hold_off_req = 1'b1;
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if (phase == 5 && n == PHASE_ITEMS / 2)
                begin
                    @(negedge clk);
                    sample_valid <= 1'b0;
                    while (pending_lowpass.size() != 0)
                        @(negedge clk);
                end
                send_sample(random_sample(n), 1'b0, '0);
            end
            quiet = 1'b0;
        end

        settle_block();
        repeat (TAIL_CYCLES) @(negedge clk);
        if (pending_lowpass.size() != 0)
            note_mismatch("low-pass words never delivered", pending_lowpass.size(), 0);
        $display("Covered %0d samples and %0d checked words over %0d register writes,",
                 samples_accepted, results_checked, writes_done);
        $display("with %0d long output hold-off and one drain pause mid-phase.", holds_done);
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/tsvf_pkg.sv
rtl/tsvf_coef.sv
rtl/tsvf_core.sv
rtl/trapezoidal_svf_lowpass.sv
rtl/tsvf_checker.sv
tb/trapezoidal_svf_lowpass_tb.sv
